### src/ucs_pkg.sv
// ----------------------------------------------------------------------------
// ucs_pkg: shared types, constants and case-mapping functions
// Holds the result bundle, the queue entry type and the per-lead
// UTF-8 upper-case rules used by the sequence converter.
// ----------------------------------------------------------------------------
package ucs_pkg;

    localparam int UCS_MAX_RESULTS = 4;
    localparam int UCS_QUEUE_DEPTH = 8;

    localparam logic [7:0] ASCII_LOWER_A  = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z  = 8'h7a;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;
    localparam logic [7:0] LEAD_MIN       = 8'hc0;
    localparam logic [7:0] LEAD_E1        = 8'he1;
    localparam logic [7:0] LEAD_F0        = 8'hf0;
    localparam logic [7:0] F0_OSAGE_PLANE = 8'h90;
    localparam logic [7:0] F0_ADLAM_PLANE = 8'h9e;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
        logic            eot;
    } ucs_result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eot;
    } ucs_entry_t;

    function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Two-byte sequences; returns {lead, continuation}.
    function automatic logic [15:0] conv_two(input logic [7:0] ld, input logic [7:0] c);
        logic [7:0] l;
        logic [7:0] b;
        logic       odd;
        l   = ld;
        b   = c;
        odd = c[0];
        case (ld)
            8'hc3:
            begin
                if (in_rng(c, 8'ha0, 8'hbe) && c != 8'hb7) b = c - 8'h20;
            end
            8'hc4:
            begin
                if ((in_rng(c, 8'h81, 8'hb8) && odd) || (in_rng(c, 8'hba, 8'hbf) && !odd))
                    b = c - 8'h01;
            end
            8'hc5:
            begin
                if (c == 8'h80)
                begin
                    l = 8'hc4;
                    b = 8'hbf;
                end
                else if ((in_rng(c, 8'h81, 8'h89) && !odd) ||
                         (in_rng(c, 8'h8b, 8'hb8) && odd) ||
                         (in_rng(c, 8'hba, 8'hbf) && !odd))
                    b = c - 8'h01;
            end
            8'hc6:
            begin
                case (c)
                    8'h83, 8'h85, 8'h88, 8'h8c, 8'h92, 8'h99,
                    8'ha1, 8'ha3, 8'ha5, 8'ha8, 8'had, 8'hb0,
                    8'hb4, 8'hb6, 8'hb9, 8'hbd: b = c - 8'h01;
                    default: b = c;
                endcase
            end
            8'hc7:
            begin
                if (c == 8'h86 || c == 8'h85) b = 8'h84;
                else if (c == 8'h89 || c == 8'h88) b = 8'h87;
                else if (c == 8'h8c || c == 8'h8b) b = 8'h8a;
                else if (in_rng(c, 8'h8e, 8'h9d) && !odd) b = c - 8'h01;
                else if (in_rng(c, 8'h9f, 8'hb0) && odd) b = c - 8'h01;
                else if (c == 8'hb3) b = 8'hb1;
                else if (c == 8'hb5 || c == 8'hb9 || c == 8'hbb || c == 8'hbd ||
                         c == 8'hbf)
                    b = c - 8'h01;
            end
            8'hc8:
            begin
                if ((in_rng(c, 8'h81, 8'ha0) && odd) || (in_rng(c, 8'ha3, 8'hb4) && odd) ||
                    c == 8'hbc)
                    b = c - 8'h01;
            end
            8'hcd:
            begin
                if (c == 8'hb1 || c == 8'hb3 || c == 8'hb7) b = c - 8'h01;
            end
            8'hce:
            begin
                if (c == 8'hac) b = 8'h86;
                else if (c == 8'had) b = 8'h88;
                else if (c == 8'hae) b = 8'h89;
                else if (c == 8'haf) b = 8'h8a;
                else if (in_rng(c, 8'hb1, 8'hbf)) b = c - 8'h20;
            end
            8'hcf:
            begin
                if (c == 8'h8c)
                begin
                    l = 8'hce;
                    b = 8'h8c;
                end
                else if (c == 8'h8d)
                begin
                    l = 8'hce;
                    b = 8'h8e;
                end
                else if (c == 8'h8e)
                begin
                    l = 8'hce;
                    b = 8'h8f;
                end
                else if (in_rng(c, 8'h80, 8'h8b) && c != 8'h82)
                begin
                    l = 8'hce;
                    b = c + 8'h20;
                end
                else if (c == 8'h91) b = 8'h90;
                else if (c == 8'hb4) b = 8'h8f;
                else if (in_rng(c, 8'h99, 8'hb0) && odd) b = c - 8'h01;
                else if (c == 8'hb2) b = 8'hb9;
                else if (c == 8'hb3)
                begin
                    l = 8'hcd;
                    b = 8'hbf;
                end
                else if (c == 8'hbc)
                begin
                    l = 8'hcd;
                    b = 8'hbb;
                end
                else if (c == 8'hbd)
                begin
                    l = 8'hcd;
                    b = 8'hbc;
                end
                else if (c == 8'hbe)
                begin
                    l = 8'hcd;
                    b = 8'hbd;
                end
            end
            8'hd0:
            begin
                if (in_rng(c, 8'hb0, 8'hbf)) b = c - 8'h20;
            end
            8'hd1:
            begin
                if (in_rng(c, 8'h80, 8'h8f))
                begin
                    l = 8'hd0;
                    b = c + 8'h20;
                end
                else if (in_rng(c, 8'h90, 8'h9f))
                begin
                    l = 8'hd0;
                    b = c - 8'h10;
                end
                else if (in_rng(c, 8'ha1, 8'hbf) && odd) b = c - 8'h01;
            end
            8'hd2:
            begin
                if (c == 8'h81 || (in_rng(c, 8'h8b, 8'hbf) && odd)) b = c - 8'h01;
            end
            8'hd3:
            begin
                if ((in_rng(c, 8'h82, 8'h8f) && !odd) || (in_rng(c, 8'h91, 8'hbf) && odd))
                    b = c - 8'h01;
            end
            8'hd4:
            begin
                if (in_rng(c, 8'h81, 8'hb0) && odd) b = c - 8'h01;
            end
            8'hd5:
            begin
                if (in_rng(c, 8'ha1, 8'haf))
                begin
                    l = 8'hd4;
                    b = c + 8'h10;
                end
                else if (in_rng(c, 8'h81, 8'h97) && odd) b = c - 8'h01;
            end
            default:
            begin
                b = c;
            end
        endcase
        return {l, b};
    endfunction

    // Greek Extended: rows whose lower-case letters sit 8 below their capitals.
    function automatic logic grk_ext(input logic [7:0] sel, input logic [7:0] b);
        logic hit;
        case (sel)
            8'hbc: hit = in_rng(b, 8'h80, 8'h87) || in_rng(b, 8'h90, 8'h97) ||
                         in_rng(b, 8'ha0, 8'ha7) || in_rng(b, 8'hb0, 8'hb7);
            8'hbd: hit = in_rng(b, 8'h80, 8'h85) || in_rng(b, 8'h90, 8'h97) ||
                         in_rng(b, 8'ha0, 8'ha7) || in_rng(b, 8'hb0, 8'hb7);
            8'hbe: hit = in_rng(b, 8'h80, 8'h87) || in_rng(b, 8'h90, 8'h97) ||
                         in_rng(b, 8'ha0, 8'ha7) || in_rng(b, 8'hb0, 8'hb1);
            8'hbf: hit = in_rng(b, 8'h80, 8'h84) || in_rng(b, 8'h90, 8'h93) ||
                         in_rng(b, 8'ha0, 8'ha4);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Three-byte sequences under lead E1; returns {middle, last}.
    function automatic logic [15:0] conv_e1(input logic [7:0] mid, input logic [7:0] c);
        logic [7:0] m;
        logic [7:0] b;
        logic       odd;
        m   = mid;
        b   = c;
        odd = c[0];
        case (mid)
            8'h83:
            begin
                if (in_rng(c, 8'h90, 8'haf))
                begin
                    m = 8'h82;
                    b = c + 8'h10;
                end
                else if (in_rng(c, 8'hb0, 8'hb5) || c == 8'hb7 || c == 8'hbd)
                    b = c - 8'h30;
            end
            8'hb8, 8'hb9, 8'hbb:
            begin
                if (in_rng(c, 8'h81, 8'hbf) && odd) b = c - 8'h01;
            end
            8'hba:
            begin
                if ((in_rng(c, 8'h81, 8'h95) && odd) || (in_rng(c, 8'h9f, 8'hbf) && odd))
                    b = c - 8'h01;
            end
            8'hbc, 8'hbd, 8'hbe, 8'hbf:
            begin
                if (grk_ext(mid, c)) b = c + 8'h08;
            end
            default:
            begin
                b = c;
            end
        endcase
        return {m, b};
    endfunction

    // Convert a complete sequence of n bytes, s[0] being the lead.
    function automatic logic [3:0][7:0] conv_seq(input logic [3:0][7:0] s_in,
                                                 input logic [2:0] n);
        logic [3:0][7:0] s;
        logic [15:0]     t;
        s = s_in;
        t = '0;
        if (n == 3'd2)
        begin
            t    = conv_two(s[0], s[1]);
            s[0] = t[15:8];
            s[1] = t[7:0];
        end
        else if (n == 3'd3)
        begin
            if (s[0] == LEAD_E1)
            begin
                t    = conv_e1(s[1], s[2]);
                s[1] = t[15:8];
                s[2] = t[7:0];
            end
        end
        else if (n == 3'd4)
        begin
            if (s[1] == F0_OSAGE_PLANE && s[2] == 8'h93)
            begin
                if (in_rng(s[3], 8'h98, 8'ha7))
                begin
                    s[2] = 8'h92;
                    s[3] = s[3] + 8'h18;
                end
                else if (in_rng(s[3], 8'ha8, 8'hbb))
                    s[3] = s[3] - 8'h28;
            end
            else if (s[1] == F0_ADLAM_PLANE && s[2] == 8'ha4)
            begin
                if (in_rng(s[3], 8'ha2, 8'hc3)) s[3] = s[3] - 8'h22;
            end
        end
        return s;
    endfunction

endpackage

### src/utf8_uppercase_stream.sv
// Flow: an accepted byte is registered in the input stage, then converted as it
//   leaves the stage and written into the result queue, which drives the output.
// Throughput: one input byte per cycle; results leave an 8-entry queue one byte
//   per cycle while taken, and input stalls only while under 4 entries are free.
// Reset: rst_n is asynchronous, active low; it empties the stage and the queue
//   and clears any pending sequence and the stop state.
// ----------------------------------------------------------------------------
// utf8_uppercase_stream: byte-serial UTF-8 upper-case converter
// Upper-cases a UTF-8 text region byte by byte while keeping its byte
// length; multi-byte sequences are held and released whole.
// ----------------------------------------------------------------------------
module utf8_uppercase_stream
    import ucs_pkg::*;
#(
    parameter int QUEUE_DEPTH = UCS_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input bytes
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    // converted bytes
    output logic       upper_valid,
    input  logic       upper_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_end
);

    // Input stage: one byte waiting for conversion.
    logic        stage_valid_reg;
    logic        stage_valid_next;
    logic [7:0]  stage_byte_reg;
    logic        stage_eot_reg;

    logic        room;
    logic        advance;
    logic        take;
    ucs_result_t result;

    // Convert the staged byte only when the queue can absorb a full
    // four-byte sequence; the queue, not the output handshake, gates input.
    assign advance    = stage_valid_reg && room;
    assign text_ready = !stage_valid_reg || advance;
    assign take       = text_valid && text_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // Payload needs no reset; load on every accepted item.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_byte_reg <= in_byte;
            stage_eot_reg  <= end_of_text;
        end
    end

    // Sequence tracking and case mapping; state advances with the stage.
    ucs_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item_byte (stage_byte_reg),
        .item_eot  (stage_eot_reg),
        .result    (result)
    );

    // Result queue doubles as the result register and the skid buffer.
    ucs_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (advance),
        .res         (result),
        .room        (room),
        .upper_valid (upper_valid),
        .upper_ready (upper_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .text_end    (text_end)
    );

endmodule

### src/ucs_conv.sv
// ----------------------------------------------------------------------------
// ucs_conv: sequence tracker and converter
// Collects the bytes of a multi-byte sequence and turns each staged byte
// into zero to four converted result bytes.
// ----------------------------------------------------------------------------
module ucs_conv
    import ucs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  item_byte,
    input  logic        item_eot,
    output ucs_result_t result
);

    logic [7:0]      held_reg [3];
    logic [1:0]      held_count_reg;
    logic [1:0]      held_count_next;
    logic [2:0]      seq_len_reg;
    logic [2:0]      seq_len_next;
    logic            stopped_reg;
    logic            stopped_next;

    logic [3:0][7:0] raw;
    logic [3:0][7:0] conv;
    logic [2:0]      raw_n;
    logic [2:0]      seq_eff;
    logic            complete;
    logic            hold_write;

    // Held bytes in order, then the staged byte.
    always_comb
    begin
        raw[0] = (held_count_reg == 2'd0) ? item_byte : held_reg[0];
        raw[1] = (held_count_reg == 2'd1) ? item_byte : held_reg[1];
        raw[2] = (held_count_reg == 2'd2) ? item_byte : held_reg[2];
        raw[3] = item_byte;
        raw_n  = {1'b0, held_count_reg} + 3'd1;
    end

    assign conv = conv_seq(raw, raw_n);

    always_comb
    begin
        seq_eff = seq_len_reg;
        if (held_count_reg == 2'd1 && held_reg[0] == LEAD_F0 &&
            (item_byte == F0_OSAGE_PLANE || item_byte == F0_ADLAM_PLANE))
            seq_eff = 3'd4;
        complete = (raw_n >= seq_eff) || (held_count_reg == 2'd3);
    end

    always_comb
    begin
        result.bytes    = raw;
        result.cnt      = 3'd0;
        result.eot      = item_eot;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        stopped_next    = stopped_reg;
        hold_write      = 1'b0;

        if (stopped_reg)
        begin
            result.cnt = 3'd1;
        end
        else if (held_count_reg == 2'd0)
        begin
            if (item_byte == 8'h00)
            begin
                stopped_next = 1'b1;
                result.cnt   = 3'd1;
            end
            else if (item_byte >= ASCII_LOWER_A && item_byte <= ASCII_LOWER_Z)
            begin
                result.bytes[0] = item_byte - CASE_OFFSET;
                result.cnt      = 3'd1;
            end
            else if (item_byte > LEAD_MIN)
            begin
                // open a sequence; end of text flushes the lead unchanged
                hold_write      = 1'b1;
                held_count_next = 2'd1;
                seq_len_next    = (item_byte == LEAD_E1 || item_byte == LEAD_F0) ? 3'd3 : 3'd2;
                result.cnt      = item_eot ? 3'd1 : 3'd0;
            end
            else
            begin
                result.cnt = 3'd1;
            end
        end
        else if (complete)
        begin
            result.bytes    = conv;
            result.cnt      = raw_n;
            held_count_next = 2'd0;
            seq_len_next    = 3'd0;
        end
        else
        begin
            hold_write      = 1'b1;
            held_count_next = held_count_reg + 2'd1;
            seq_len_next    = seq_eff;
            result.cnt      = item_eot ? raw_n : 3'd0;
        end

        if (item_eot)
        begin
            held_count_next = 2'd0;
            seq_len_next    = 3'd0;
            stopped_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
            stopped_reg    <= 1'b0;
        end
        else if (advance)
        begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
            stopped_reg    <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hold_write)
            held_reg[held_count_reg] <= item_byte;
    end

endmodule

### src/ucs_outq.sv
// ----------------------------------------------------------------------------
// ucs_outq: result queue
// Takes up to four result bytes per cycle and hands them out one per
// accepted item, in order.
// ----------------------------------------------------------------------------
module ucs_outq
    import ucs_pkg::*;
#(
    parameter int DEPTH = UCS_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ucs_result_t res,
    output logic        room,
    output logic        upper_valid,
    input  logic        upper_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        text_end
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - UCS_MAX_RESULTS);
    localparam logic [PW:0]   DEPTH_W    = (PW + 1)'(DEPTH);

    ucs_entry_t      entry_reg [DEPTH];
    logic [PW-1:0]   head_reg;
    logic [PW-1:0]   head_next;
    logic [PW-1:0]   tail_reg;
    logic [PW-1:0]   tail_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [PW-1:0]   wr_idx [UCS_MAX_RESULTS];
    logic [2:0]      push_n;
    logic            pop;

    function automatic logic [PW-1:0] wrap(input logic [PW:0] v);
        logic [PW:0] r;
        r = (v >= DEPTH_W) ? v - DEPTH_W : v;
        return r[PW-1:0];
    endfunction

    assign pop         = upper_valid && upper_ready;
    assign push_n      = push ? res.cnt : 3'd0;
    assign upper_valid = (count_reg != '0);
    assign room        = (count_reg <= ROOM_LIMIT);
    assign out_byte    = entry_reg[head_reg].data;
    assign run_last    = entry_reg[head_reg].last;
    assign text_end    = entry_reg[head_reg].eot;

    always_comb
    begin
        for (int k = 0; k < UCS_MAX_RESULTS; k++)
            wr_idx[k] = wrap({1'b0, tail_reg} + (PW + 1)'(k));
        tail_next  = wrap({1'b0, tail_reg} + (PW + 1)'(push_n));
        head_next  = pop ? wrap({1'b0, head_reg} + (PW + 1)'(1)) : head_reg;
        count_next = count_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < UCS_MAX_RESULTS; k++)
        begin
            if (3'(k) < push_n)
            begin
                entry_reg[wr_idx[k]].data <= res.bytes[k];
                entry_reg[wr_idx[k]].last <= (3'(k) == push_n - 3'd1);
                entry_reg[wr_idx[k]].eot  <= res.eot;
            end
        end
    end

endmodule

### src/ucs_checker.sv
// ----------------------------------------------------------------------------
// ucs_checker: port-level checks for utf8_uppercase_stream
// Watches the output grouping, the input and output hold rules and the input
// back-pressure over time.
// ----------------------------------------------------------------------------
module ucs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       text_valid,
    input logic       text_ready,
    input logic [7:0] in_byte,
    input logic       end_of_text,
    input logic       upper_valid,
    input logic       upper_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       text_end
);

    // Hold an offered input item until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(in_byte) &&
        $stable(end_of_text))
        else $error("input item changed while waiting");

    // Hold a stalled result steady.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        upper_valid && !upper_ready |=> upper_valid && $stable(out_byte) &&
        $stable(run_last) && $stable(text_end))
        else $error("result changed while stalled");

    // Deliver the rest of a group in the very next cycle.
    a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
        upper_valid && upper_ready && !run_last |=> upper_valid)
        else $error("result group broken up");

    // Keep the end mark uniform across one group.
    a_group_end: assert property (@(posedge clk) disable iff (!rst_n)
        upper_valid && upper_ready && !run_last |=> text_end == $past(text_end))
        else $error("end mark differs inside a group");

    // With nothing waiting on the output, input must be open.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !upper_valid |-> text_ready)
        else $error("input stalled with empty output");

endmodule

bind utf8_uppercase_stream ucs_checker u_ucs_checker (.*);

### bench/tb_utf8_uppercase_stream.sv
// ----------------------------------------------------------------------------
// tb_utf8_uppercase_stream: self-checking bench for the UTF-8 upper-caser
// Walks a short table of directed bytes, then a long run of random text
// built mostly from well-formed sequences of the handled scripts. Every
// accepted byte runs through a local case-mapping predictor, and every
// output item is compared against the oldest predicted item.
// ----------------------------------------------------------------------------
module tb_utf8_uppercase_stream
    import ucs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 420;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_LIMIT  = 20;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       text_valid  = 1'b0;
    logic [7:0] in_byte     = 8'h00;
    logic       end_of_text = 1'b0;
    logic       upper_ready = 1'b0;
    logic       text_ready;
    logic       upper_valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    always #6 clk = ~clk;

    utf8_uppercase_stream i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .upper_valid (upper_valid),
        .upper_ready (upper_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .text_end    (text_end)
    );

    // ------------------------------------------------------------------
    // Predictor state: a pending multi-byte sequence and the stop state
    // ------------------------------------------------------------------
    logic [2:0][7:0] pending_bytes;
    int              pending_cnt;
    int              pending_len;
    logic            conv_stopped;

    // Predicted output items, oldest first
    ucs_entry_t      upper_expect_q[$];

    // Directed table rows: typed rows carry their own expected bytes,
    // lowest byte going out first
    typedef struct {
        logic [7:0]      data;
        logic            eot;
        bit              typed;
        int              cnt;
        logic [3:0][7:0] want;
    } text_row_t;

    text_row_t       directed_q[$];
    logic [7:0]      token_q[$];

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  region_ends    = 0;
    int  cut_sequences  = 0;
    int  stop_regions   = 0;
    int  burst_left     = 0;

    // ------------------------------------------------------------------
    // Case-mapping rules
    // ------------------------------------------------------------------
    function automatic logic between(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Two-byte sequence; returns {lead, continuation}
    function automatic logic [15:0] upcase_pair(input logic [7:0] ld, input logic [7:0] c);
        logic [7:0] l;
        logic [7:0] b;
        logic       odd;
        l   = ld;
        b   = c;
        odd = c[0];
        case (ld)
            8'hc3:
            begin
                if (between(c, 8'ha0, 8'hbe) && c != 8'hb7) b = c - 8'h20;
            end
            8'hc4:
            begin
                if ((between(c, 8'h81, 8'hb8) && odd) || (between(c, 8'hba, 8'hbf) && !odd))
                    b = c - 8'h01;
            end
            8'hc5:
            begin
                if (c == 8'h80)
                begin
                    l = 8'hc4;
                    b = 8'hbf;
                end
                else if ((between(c, 8'h81, 8'h89) && !odd) ||
                         (between(c, 8'h8b, 8'hb8) && odd) ||
                         (between(c, 8'hba, 8'hbf) && !odd))
                    b = c - 8'h01;
            end
            8'hc6:
            begin
                case (c)
                    8'h83, 8'h85, 8'h88, 8'h8c, 8'h92, 8'h99, 8'ha1, 8'ha3,
                    8'ha5, 8'ha8, 8'had, 8'hb0, 8'hb4, 8'hb6, 8'hb9, 8'hbd:
                        b = c - 8'h01;
                    default:
                        b = c;
                endcase
            end
            8'hc7:
            begin
                if (c == 8'h85 || c == 8'h86) b = 8'h84;
                else if (c == 8'h88 || c == 8'h89) b = 8'h87;
                else if (c == 8'h8b || c == 8'h8c) b = 8'h8a;
                else if (between(c, 8'h8e, 8'h9d) && !odd) b = c - 8'h01;
                else if (between(c, 8'h9f, 8'hb0) && odd) b = c - 8'h01;
                else if (c == 8'hb3) b = 8'hb1;
                else if (c == 8'hb5 || c == 8'hb9 || c == 8'hbb || c == 8'hbd ||
                         c == 8'hbf)
                    b = c - 8'h01;
            end
            8'hc8:
            begin
                if ((between(c, 8'h81, 8'ha0) && odd) ||
                    (between(c, 8'ha3, 8'hb4) && odd) || c == 8'hbc)
                    b = c - 8'h01;
            end
            8'hcd:
            begin
                if (c == 8'hb1 || c == 8'hb3 || c == 8'hb7) b = c - 8'h01;
            end
            8'hce:
            begin
                if (c == 8'hac) b = 8'h86;
                else if (c == 8'had) b = 8'h88;
                else if (c == 8'hae) b = 8'h89;
                else if (c == 8'haf) b = 8'h8a;
                else if (between(c, 8'hb1, 8'hbf)) b = c - 8'h20;
            end
            8'hcf:
            begin
                // Small letters up to CF 8E, final sigma apart, move back to the CE lead
                if (c == 8'h8c) {l, b} = {8'hce, 8'h8c};
                else if (c == 8'h8d) {l, b} = {8'hce, 8'h8e};
                else if (c == 8'h8e) {l, b} = {8'hce, 8'h8f};
                else if (between(c, 8'h80, 8'h8b) && c != 8'h82)
                    {l, b} = {8'hce, c + 8'h20};
                else if (c == 8'h91) b = 8'h90;
                else if (c == 8'hb4) b = 8'h8f;
                else if (between(c, 8'h99, 8'hb0) && odd) b = c - 8'h01;
                else if (c == 8'hb2) b = 8'hb9;
                else if (c == 8'hb3) {l, b} = {8'hcd, 8'hbf};
                else if (c == 8'hbc) {l, b} = {8'hcd, 8'hbb};
                else if (c == 8'hbd) {l, b} = {8'hcd, 8'hbc};
                else if (c == 8'hbe) {l, b} = {8'hcd, 8'hbd};
            end
            8'hd0:
            begin
                if (between(c, 8'hb0, 8'hbf)) b = c - 8'h20;
            end
            8'hd1:
            begin
                if (between(c, 8'h80, 8'h8f)) {l, b} = {8'hd0, c + 8'h20};
                else if (between(c, 8'h90, 8'h9f)) {l, b} = {8'hd0, c - 8'h10};
                else if (between(c, 8'ha1, 8'hbf) && odd) b = c - 8'h01;
            end
            8'hd2:
            begin
                if (c == 8'h81 || (between(c, 8'h8b, 8'hbf) && odd)) b = c - 8'h01;
            end
            8'hd3:
            begin
                if ((between(c, 8'h82, 8'h8f) && !odd) || (between(c, 8'h91, 8'hbf) && odd))
                    b = c - 8'h01;
            end
            8'hd4:
            begin
                if (between(c, 8'h81, 8'hb0) && odd) b = c - 8'h01;
            end
            8'hd5:
            begin
                if (between(c, 8'ha1, 8'haf)) {l, b} = {8'hd4, c + 8'h10};
                else if (between(c, 8'h81, 8'h97) && odd) b = c - 8'h01;
            end
            default:
            begin
                b = c;
            end
        endcase
        return {l, b};
    endfunction

    // Greek Extended rows whose small letters sit 8 below the capitals
    function automatic logic greek_row_hit(input logic [7:0] row, input logic [7:0] c);
        case (row)
            8'hbc: return between(c, 8'h80, 8'h87) || between(c, 8'h90, 8'h97) ||
                          between(c, 8'ha0, 8'ha7) || between(c, 8'hb0, 8'hb7);
            8'hbd: return between(c, 8'h80, 8'h85) || between(c, 8'h90, 8'h97) ||
                          between(c, 8'ha0, 8'ha7) || between(c, 8'hb0, 8'hb7);
            8'hbe: return between(c, 8'h80, 8'h87) || between(c, 8'h90, 8'h97) ||
                          between(c, 8'ha0, 8'ha7) || between(c, 8'hb0, 8'hb1);
            8'hbf: return between(c, 8'h80, 8'h84) || between(c, 8'h90, 8'h93) ||
                          between(c, 8'ha0, 8'ha4);
            default: return 1'b0;
        endcase
    endfunction

    // Three-byte sequence under lead E1; returns {middle, last}
    function automatic logic [15:0] upcase_e1(input logic [7:0] mid, input logic [7:0] c);
        logic [7:0] m;
        logic [7:0] b;
        m = mid;
        b = c;
        case (mid)
            8'h83:
            begin
                // Georgian: small letters up to AF fold back into the 82 row, the rest stay in 83
                if (between(c, 8'h90, 8'haf)) {m, b} = {8'h82, c + 8'h10};
                else if (between(c, 8'hb0, 8'hb5) || c == 8'hb7 || c == 8'hbd)
                    b = c - 8'h30;
            end
            8'hb8, 8'hb9, 8'hbb:
            begin
                if (between(c, 8'h81, 8'hbf) && c[0]) b = c - 8'h01;
            end
            8'hba:
            begin
                if ((between(c, 8'h81, 8'h95) || between(c, 8'h9f, 8'hbf)) && c[0])
                    b = c - 8'h01;
            end
            8'hbc, 8'hbd, 8'hbe, 8'hbf:
            begin
                if (greek_row_hit(mid, c)) b = c + 8'h08;
            end
            default:
            begin
                b = c;
            end
        endcase
        return {m, b};
    endfunction

    // Convert a complete sequence of n bytes, s[0] being the lead
    function automatic logic [3:0][7:0] upcase_run(input logic [3:0][7:0] s_in, input int n);
        logic [3:0][7:0] s;
        logic [15:0]     pair;
        s = s_in;
        if (n == 2)
        begin
            pair = upcase_pair(s[0], s[1]);
            s[0] = pair[15:8];
            s[1] = pair[7:0];
        end
        else if (n == 3 && s[0] == LEAD_E1)
        begin
            pair = upcase_e1(s[1], s[2]);
            s[1] = pair[15:8];
            s[2] = pair[7:0];
        end
        else if (n == 4)
        begin
            // Osage: the low small letters move to the 92 row, the rest stay in 93
            if (s[1] == F0_OSAGE_PLANE && s[2] == 8'h93)
            begin
                if (between(s[3], 8'h98, 8'ha7))
                begin
                    s[2] = 8'h92;
                    s[3] = s[3] + 8'h18;
                end
                else if (between(s[3], 8'ha8, 8'hbb))
                    s[3] = s[3] - 8'h28;
            end
            else if (s[1] == F0_ADLAM_PLANE && s[2] == 8'ha4 && between(s[3], 8'ha2, 8'hc3))
                s[3] = s[3] - 8'h22;
        end
        return s;
    endfunction

    // Advance the predictor by one accepted byte; give the bytes it releases
    task automatic upcase_step(input logic [7:0] b, input logic eot,
                               output logic [3:0][7:0] res, output int n);
        n   = 0;
        res = '0;
        if (conv_stopped)
        begin
            res[n] = b;
            n++;
        end
        else if (pending_cnt == 0)
        begin
            if (b == 8'h00)
            begin
                conv_stopped = 1'b1;
                stop_regions++;
                res[n] = b;
                n++;
            end
            else if (between(b, ASCII_LOWER_A, ASCII_LOWER_Z))
            begin
                res[n] = b - CASE_OFFSET;
                n++;
            end
            else if (b > LEAD_MIN)
            begin
                pending_bytes[0] = b;
                pending_cnt      = 1;
                pending_len      = (b == LEAD_E1 || b == LEAD_F0) ? 3 : 2;
            end
            else
            begin
                res[n] = b;
                n++;
            end
        end
        else
        begin
            if (pending_cnt == 1 && pending_bytes[0] == LEAD_F0 &&
                (b == F0_OSAGE_PLANE || b == F0_ADLAM_PLANE))
                pending_len = 4;
            if (pending_cnt + 1 >= pending_len || pending_cnt >= 3)
            begin
                for (int k = 0; k < pending_cnt; k++)
                begin
                    res[n] = pending_bytes[k];
                    n++;
                end
                res[n] = b;
                n++;
                res         = upcase_run(res, n);
                pending_cnt = 0;
                pending_len = 0;
            end
            else
            begin
                pending_bytes[pending_cnt] = b;
                pending_cnt++;
            end
        end
        if (eot)
        begin
            // Flush anything still held, unconverted, and leave the stop state
            region_ends++;
            if (pending_cnt > 0) cut_sequences++;
            for (int k = 0; k < pending_cnt; k++)
            begin
                res[n] = pending_bytes[k];
                n++;
            end
            pending_cnt  = 0;
            pending_len  = 0;
            conv_stopped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch up to PRINT_LIMIT, count them all
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s mismatch: got 0x%02h, expected 0x%02h", $realtime, what, got,
                     want);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps between them.
    // Raise valid at an edge, hold it with the payload until accepted.
    // Valid is only lowered when a gap follows, so it never sees two
    // assignments in one step.
    // ------------------------------------------------------------------
    task automatic send_text(input logic [7:0] b, input logic eot);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid  <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (!text_ready);
        items_sent++;
    endtask

    // Send one byte and queue what it should release; typed rows use
    // their own expected bytes, all others the predictor's
    task automatic feed_text(input text_row_t row);
        logic [3:0][7:0] res;
        int              n;
        send_text(row.data, row.eot);
        upcase_step(row.data, row.eot, res, n);
        if (row.typed)
        begin
            res = row.want;
            n   = row.cnt;
        end
        for (int k = 0; k < n; k++)
            upper_expect_q.push_back('{data: res[k], last: (k == n - 1), eot: row.eot});
    endtask

    task automatic add_row(input logic [7:0] data, input logic eot, input bit typed,
                           input int cnt, input logic [31:0] want);
        text_row_t row;
        row.data  = data;
        row.eot   = eot;
        row.typed = typed;
        row.cnt   = cnt;
        row.want  = want;
        directed_q.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Random text: mostly well-formed sequences of the handled scripts,
    // with noise, zero bytes and the odd malformed continuation mixed in
    // ------------------------------------------------------------------
    function automatic logic [7:0] cont_byte();
        return ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(8'h80, 8'hbf));
    endfunction

    task automatic build_token();
        int kind;
        int lead;
        kind = $urandom_range(0, 99);
        token_q.delete();
        if (kind < 25)
        begin
            if ($urandom_range(0, 9) < 6)
                token_q.push_back(8'($urandom_range(ASCII_LOWER_A, ASCII_LOWER_Z)));
            else
                token_q.push_back(8'($urandom_range(1, 127)));
        end
        else if (kind < 55)
        begin
            // Two-byte sequence, weighted toward the leads that have rules
            lead = ($urandom_range(0, 3) == 0) ? $urandom_range(8'hc1, 8'hdf)
                                               : $urandom_range(8'hc3, 8'hd5);
            token_q.push_back(8'(lead));
            token_q.push_back(cont_byte());
        end
        else if (kind < 70)
        begin
            token_q.push_back(LEAD_E1);
            if ($urandom_range(0, 3) == 0)
                token_q.push_back(cont_byte());
            else if ($urandom_range(0, 3) == 0)
                token_q.push_back(8'h83);
            else
                token_q.push_back(8'($urandom_range(8'hb8, 8'hbf)));
            token_q.push_back(cont_byte());
        end
        else if (kind < 85)
        begin
            // Four-byte Osage or Adlam sequence
            token_q.push_back(LEAD_F0);
            if ($urandom_range(0, 1) == 0)
            begin
                token_q.push_back(F0_OSAGE_PLANE);
                token_q.push_back(($urandom_range(0, 4) == 0) ? cont_byte() : 8'h93);
                token_q.push_back(8'($urandom_range(8'h80, 8'hc7)));
            end
            else
            begin
                token_q.push_back(F0_ADLAM_PLANE);
                token_q.push_back(($urandom_range(0, 4) == 0) ? cont_byte() : 8'ha4);
                token_q.push_back(8'($urandom_range(8'h80, 8'hc7)));
            end
        end
        else if (kind < 89)
        begin
            // Three-byte F0 sequence: second byte is not a four-byte plane
            token_q.push_back(LEAD_F0);
            do
                lead = $urandom_range(0, 255);
            while (lead == F0_OSAGE_PLANE || lead == F0_ADLAM_PLANE);
            token_q.push_back(8'(lead));
            token_q.push_back(cont_byte());
        end
        else if (kind < 92)
        begin
            token_q.push_back(8'h00);
        end
        else
        begin
            repeat ($urandom_range(1, 4)) token_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern that changes mode every so often
    // (always ready, coin toss, a fixed duty cycle, long stalls)
    // ------------------------------------------------------------------
    int pace_mode = 0;
    int pace_left = 0;
    int pace_tick = 0;

    always @(posedge clk)
    begin
        pace_tick <= pace_tick + 1;
        if (pace_left == 0)
        begin
            pace_mode <= $urandom_range(0, 3);
            pace_left <= $urandom_range(20, 150);
        end
        else
            pace_left <= pace_left - 1;
        case (pace_mode)
            0: upper_ready <= 1'b1;
            1: upper_ready <= 1'($urandom_range(0, 1));
            2: upper_ready <= (pace_tick % 5) < 2;
            default: upper_ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Output check: compare each accepted item with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ucs_entry_t want;
        if (rst_n && upper_valid && upper_ready)
        begin
            results_seen++;
            if (upper_expect_q.size() == 0)
                report_mismatch("unexpected item", out_byte, 8'h00);
            else
            begin
                want = upper_expect_q.pop_front();
                if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
                if (run_last !== want.last)
                    report_mismatch("run_last", {7'd0, run_last}, {7'd0, want.last});
                if (text_end !== want.eot)
                    report_mismatch("text_end", {7'd0, text_end}, {7'd0, want.eot});
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run at a generous cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("utf8_uppercase_stream test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        text_row_t row;

        pending_bytes = '0;
        pending_cnt   = 0;
        pending_len   = 0;
        conv_stopped  = 1'b0;

        // Directed table; typed rows can be read off the rules directly
        add_row(8'h61, 1'b0, 1, 1, 32'h41);        // lowest lower-case letter
        add_row(8'h7a, 1'b0, 1, 1, 32'h5a);        // highest lower-case letter
        add_row(8'h60, 1'b0, 1, 1, 32'h60);        // just below the letters
        add_row(8'h80, 1'b0, 1, 1, 32'h80);        // stray continuation byte
        add_row(8'hc0, 1'b0, 1, 1, 32'hc0);        // highest byte that is no lead
        add_row(8'hc3, 1'b0, 1, 0, 32'h0);         // lead alone: hold, no output
        add_row(8'ha9, 1'b0, 0, 0, 32'h0);         // Latin-1 small e acute
        add_row(8'hd1, 1'b0, 0, 0, 32'h0);         // Cyrillic, low range end
        add_row(8'h8f, 1'b0, 0, 0, 32'h0);
        add_row(8'hd1, 1'b0, 0, 0, 32'h0);         // Cyrillic, high range start
        add_row(8'h90, 1'b0, 0, 0, 32'h0);
        add_row(8'he1, 1'b0, 0, 0, 32'h0);         // Greek Extended
        add_row(8'hbc, 1'b0, 0, 0, 32'h0);
        add_row(8'h80, 1'b0, 0, 0, 32'h0);
        add_row(8'hf0, 1'b0, 0, 0, 32'h0);         // Osage, moves to the 92 row
        add_row(8'h90, 1'b0, 0, 0, 32'h0);
        add_row(8'h93, 1'b0, 0, 0, 32'h0);
        add_row(8'h98, 1'b0, 0, 0, 32'h0);
        add_row(8'hf0, 1'b0, 0, 0, 32'h0);         // Adlam, top of range
        add_row(8'h9e, 1'b0, 0, 0, 32'h0);
        add_row(8'ha4, 1'b0, 0, 0, 32'h0);
        add_row(8'hc3, 1'b0, 0, 0, 32'h0);
        add_row(8'hff, 1'b0, 0, 0, 32'h0);         // zero inside a sequence
        add_row(8'h00, 1'b0, 0, 0, 32'h0);
        add_row(8'he1, 1'b0, 1, 0, 32'h0);         // sequence cut by end of text
        add_row(8'hb8, 1'b1, 1, 2, 32'hb8e1);
        add_row(8'h00, 1'b0, 1, 1, 32'h00);        // zero at lead: stop converting
        add_row(8'h61, 1'b1, 1, 1, 32'h61);        // passes raw, ends the region
        add_row(8'hff, 1'b1, 1, 1, 32'hff);        // lead on the final byte: flush

        // Hold reset, then release it once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_q[i]) feed_text(directed_q[i]);

        // Random text; end of text falls anywhere, mid-sequence included
        row.typed = 0;
        row.cnt   = 0;
        row.want  = '0;
        while (items_sent < directed_q.size() + RANDOM_ITEMS)
        begin
            build_token();
            foreach (token_q[i])
            begin
                row.data = token_q[i];
                row.eot  = ($urandom_range(0, 23) == 0);
                feed_text(row);
            end
        end

        // Drop valid, drain the output, then let the pipe settle
        text_valid <= 1'b0;
        while (upper_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes, checked %0d output items, %0d mismatches",
                 items_sent, results_seen, mismatch_count);
        $display("covered %0d region ends (%0d cutting a sequence) and %0d zero stops",
                 region_ends, cut_sequences, stop_regions);
        if (mismatch_count == 0)
            $display("utf8_uppercase_stream test passed");
        else
            $display("utf8_uppercase_stream test failed");
        $finish;
    end

endmodule
